/* hdl/ida_pkg.sv */
// Shared types and constants of the id allocator.
package ida_pkg;

    localparam int DEF_TABLE_SIZE = 256;

    // Fixed list anchors at the bottom of the link table.
    localparam int ANCHOR_ALLOC_HEAD = 0;
    localparam int ANCHOR_ALLOC_TAIL = 1;
    localparam int ANCHOR_FREE_HEAD  = 2;
    localparam int ANCHOR_FREE_TAIL  = 3;
    localparam int FIRST_ID          = 4;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_DOUBLE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_LINK,
        S_DONE
    } t_state;

    // Write enables toward the link memory.
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic flag_we;
        logic flag_val;
    } t_mem_wr;

    // One result word.
    typedef struct packed {
        t_status    status;
        logic [7:0] granted_id;
        logic       oldest_valid;
        logic [7:0] oldest_id;
        logic [7:0] alloc_count;
    } t_result;

endpackage

/* hdl/ida_req_if.sv */
// Request channel of the id allocator.
interface ida_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] entry_id;

    modport source (output valid, output mode, output entry_id, input ready);
    modport sink   (input valid, input mode, input entry_id, output ready);
endinterface

/* hdl/ida_rsp_if.sv */
// Result channel of the id allocator.
interface ida_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] granted_id;
    logic       oldest_valid;
    logic [7:0] oldest_id;
    logic [7:0] alloc_count;

    modport source (output valid, output status, output granted_id, output oldest_valid,
                    output oldest_id, output alloc_count, input ready);
    modport sink   (input valid, input status, input granted_id, input oldest_valid,
                    input oldest_id, input alloc_count, output ready);
endinterface

/* hdl/ida_link_mem.sv */
// Link table memories: next links, prev links and allocated flags.
module ida_link_mem
    import ida_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [AW-1:0] o_rd_next,
    output logic [AW-1:0] o_rd_prev,
    output logic          o_rd_flag,
    input  t_mem_wr       i_wr,
    input  logic [AW-1:0] i_next_addr,
    input  logic [AW-1:0] i_next_data,
    input  logic [AW-1:0] i_prev_addr,
    input  logic [AW-1:0] i_prev_data,
    input  logic [AW-1:0] i_flag_addr
);

    logic [AW-1:0] r_next_mem [TABLE_SIZE];
    logic [AW-1:0] r_prev_mem [TABLE_SIZE];
    logic          r_flag_mem [TABLE_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_wr.next_we) begin
            r_next_mem[i_next_addr] <= i_next_data;
        end
        if (i_wr.prev_we) begin
            r_prev_mem[i_prev_addr] <= i_prev_data;
        end
        if (i_wr.flag_we) begin
            r_flag_mem[i_flag_addr] <= i_wr.flag_val;
        end
    end

    // Registered read, one address for all three arrays.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_next <= r_next_mem[i_rd_addr];
            o_rd_prev <= r_prev_mem[i_rd_addr];
            o_rd_flag <= r_flag_mem[i_rd_addr];
        end
    end

endmodule

/* hdl/ida_seq.sv */
// Sequencer: init sweep, list unlink and relink, anchor registers and count.
module ida_seq
    import ida_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic          i_req_mode,
    input  logic [7:0]    i_req_entry_id,
    output logic          o_res_valid,
    output t_result       o_res,
    input  logic          i_out_free,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [AW-1:0] i_rd_next,
    input  logic [AW-1:0] i_rd_prev,
    input  logic          i_rd_flag,
    output t_mem_wr       o_wr,
    output logic [AW-1:0] o_next_addr,
    output logic [AW-1:0] o_next_data,
    output logic [AW-1:0] o_prev_addr,
    output logic [AW-1:0] o_prev_data,
    output logic [AW-1:0] o_flag_addr
);

    localparam logic [AW-1:0] L_ALLOC_HEAD = AW'(ANCHOR_ALLOC_HEAD);
    localparam logic [AW-1:0] L_ALLOC_TAIL = AW'(ANCHOR_ALLOC_TAIL);
    localparam logic [AW-1:0] L_FREE_HEAD  = AW'(ANCHOR_FREE_HEAD);
    localparam logic [AW-1:0] L_FREE_TAIL  = AW'(ANCHOR_FREE_TAIL);
    localparam logic [AW-1:0] L_FIRST      = AW'(FIRST_ID);
    localparam logic [AW-1:0] L_LAST       = AW'(TABLE_SIZE - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_init_addr;
    t_mode         r_mode;
    logic [AW-1:0] r_e, r_p, r_n;
    t_status       r_pre_status, r_status;
    logic          r_ok;
    logic [AW-1:0] r_alloc_head, r_alloc_tail, r_free_head, r_free_tail;
    logic [AW-1:0] n_alloc_head, n_alloc_tail, n_free_head, n_free_tail;
    logic [AW-1:0] r_count;
    logic [AW-1:0] r_granted;

    logic          w_accept;
    t_mode         w_in_mode;
    logic          w_id_ok;
    logic [AW-1:0] w_e;
    t_status       w_pre_status;
    t_status       w_status;
    logic          w_ok;
    logic [AW-1:0] w_q;
    logic [AW-1:0] w_anchor;

    assign w_in_mode = t_mode'(i_req_mode);
    assign w_accept  = i_req_valid && o_req_ready;
    assign w_id_ok   = (i_req_entry_id >= 8'(FIRST_ID)) &&
                       (32'(i_req_entry_id) < 32'(TABLE_SIZE));

    // Entry to move: free-list head for allocate, the given id for free.
    assign w_e = (w_in_mode == MODE_FREE && w_id_ok) ? AW'(i_req_entry_id) : r_free_head;

    always_comb begin
        if (w_in_mode == MODE_ALLOC) begin
            w_pre_status = (r_free_head == L_FREE_TAIL) ? ST_FULL : ST_OK;
        end else begin
            w_pre_status = w_id_ok ? ST_OK : ST_INVALID;
        end
    end

    // Final status once the allocated flag is back from memory.
    always_comb begin
        w_status = r_pre_status;
        if (r_pre_status == ST_OK && r_mode == MODE_FREE && !i_rd_flag) begin
            w_status = ST_DOUBLE;
        end
    end
    assign w_ok = (r_state == S_READ) && (w_status == ST_OK);

    // Destination list: its tail entry and its tail anchor.
    assign w_q      = (r_mode == MODE_ALLOC) ? r_alloc_tail : r_free_tail;
    assign w_anchor = (r_mode == MODE_ALLOC) ? L_ALLOC_TAIL : L_FREE_TAIL;

    // Anchor links: unlink from the source list, then link before the tail anchor.
    always_comb begin
        n_alloc_head = r_alloc_head;
        n_free_head  = r_free_head;
        n_alloc_tail = r_alloc_tail;
        n_free_tail  = r_free_tail;
        if (w_ok) begin
            if (i_rd_prev == L_ALLOC_HEAD) n_alloc_head = i_rd_next;
            if (i_rd_prev == L_FREE_HEAD)  n_free_head  = i_rd_next;
            if (i_rd_next == L_ALLOC_TAIL) n_alloc_tail = i_rd_prev;
            if (i_rd_next == L_FREE_TAIL)  n_free_tail  = i_rd_prev;
            if (w_q == L_ALLOC_HEAD)       n_alloc_head = r_e;
            if (w_q == L_FREE_HEAD)        n_free_head  = r_e;
            if (r_mode == MODE_ALLOC) begin
                n_alloc_tail = r_e;
            end else begin
                n_free_tail = r_e;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: if (r_init_addr == L_LAST) n_state = S_IDLE;
            S_IDLE: if (w_accept) n_state = S_READ;
            S_READ: n_state = S_LINK;
            S_LINK: n_state = S_DONE;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // Outputs: handshake and memory writes per state.
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr        = '0;
        o_next_addr = r_e;
        o_next_data = w_anchor;
        o_prev_addr = r_e;
        o_prev_data = w_q;
        o_flag_addr = r_e;
        unique case (r_state)
            S_INIT: begin
                o_wr.next_we = 1'b1;
                o_wr.prev_we = 1'b1;
                o_wr.flag_we = 1'b1;
                o_next_addr  = r_init_addr;
                o_next_data  = (r_init_addr == L_LAST) ? L_FREE_TAIL : r_init_addr + 1'b1;
                o_prev_addr  = r_init_addr;
                o_prev_data  = (r_init_addr == L_FIRST) ? L_FREE_HEAD : r_init_addr - 1'b1;
                o_flag_addr  = r_init_addr;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
            end
            S_READ: begin
                // next[q] = e, prev[e] = q, flag[e]
                o_wr.next_we  = w_ok && (w_q >= L_FIRST);
                o_wr.prev_we  = w_ok;
                o_wr.flag_we  = w_ok;
                o_wr.flag_val = (r_mode == MODE_ALLOC);
                o_next_addr   = w_q;
                o_next_data   = r_e;
            end
            S_LINK: begin
                // next[p] = n, prev[n] = p
                o_wr.next_we = r_ok && (r_p >= L_FIRST);
                o_wr.prev_we = r_ok && (r_n >= L_FIRST);
                o_next_addr  = r_p;
                o_next_data  = r_n;
                o_prev_addr  = r_n;
                o_prev_data  = r_p;
            end
            S_DONE: begin
                // next[e] = tail anchor
                o_wr.next_we = r_ok;
                o_res_valid  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_rd_en   = w_accept;
    assign o_rd_addr = w_e;

    always_comb begin
        o_res.status       = r_status;
        o_res.granted_id   = 8'(r_granted);
        o_res.oldest_valid = (r_alloc_head != L_ALLOC_TAIL);
        o_res.oldest_id    = (r_alloc_head != L_ALLOC_TAIL) ? 8'(r_alloc_head) : 8'd0;
        o_res.alloc_count  = 8'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_addr  <= '0;
            r_alloc_head <= L_ALLOC_TAIL;
            r_alloc_tail <= L_ALLOC_HEAD;
            r_free_head  <= L_FIRST;
            r_free_tail  <= L_LAST;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_alloc_head <= n_alloc_head;
            r_alloc_tail <= n_alloc_tail;
            r_free_head  <= n_free_head;
            r_free_tail  <= n_free_tail;
            if (r_state == S_INIT) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
            if (w_ok) begin
                r_count <= (r_mode == MODE_ALLOC) ? r_count + 1'b1 : r_count - 1'b1;
            end
        end
    end

    // Per-word working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode       <= w_in_mode;
            r_e          <= w_e;
            r_pre_status <= w_pre_status;
        end
        if (r_state == S_READ) begin
            r_p       <= i_rd_prev;
            r_n       <= i_rd_next;
            r_ok      <= w_ok;
            r_status  <= w_status;
            r_granted <= (w_ok && r_mode == MODE_ALLOC) ? r_e : '0;
        end
    end

endmodule

/* hdl/id_allocator_linked_lists.sv */
// Top level of the id allocator with doubly linked free and allocated lists.
//
//  channel  | dir | word fields                                              | handshake
//  ---------+-----+----------------------------------------------------------+-------------
//  i_req    | in  | mode, entry_id                                           | valid/ready
//  o_rsp    | out | status, granted_id, oldest_valid, oldest_id, alloc_count | valid/ready
//
// Each word passes the states IDLE, READ, LINK and DONE: accept with the link read,
// check the allocated flag and link the entry at the destination tail, unlink it
// from its old neighbors, then close its next link and hand the result over.
// The single write port of each link memory is what splits the writes over these states.
// After reset an init sweep over all TABLE_SIZE entries chains the free list; no
// request is taken until it ends. A stalled result waits in the output
// register; the sequencer holds in its last step until the register frees.
module id_allocator_linked_lists
    import ida_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ida_req_if.sink   i_req,
    ida_rsp_if.source o_rsp
);

    localparam int AW = $clog2(TABLE_SIZE);

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_rd_next, w_rd_prev;
    logic          w_rd_flag;
    t_mem_wr       w_wr;
    logic [AW-1:0] w_next_addr, w_next_data;
    logic [AW-1:0] w_prev_addr, w_prev_data;
    logic [AW-1:0] w_flag_addr;

    logic          w_res_valid;
    t_result       w_res;
    logic          w_out_free;

    logic          r_out_valid;
    t_result       r_out;

    ida_seq #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req.valid),
        .o_req_ready    (i_req.ready),
        .i_req_mode     (i_req.mode),
        .i_req_entry_id (i_req.entry_id),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .i_out_free     (w_out_free),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_next      (w_rd_next),
        .i_rd_prev      (w_rd_prev),
        .i_rd_flag      (w_rd_flag),
        .o_wr           (w_wr),
        .o_next_addr    (w_next_addr),
        .o_next_data    (w_next_data),
        .o_prev_addr    (w_prev_addr),
        .o_prev_data    (w_prev_data),
        .o_flag_addr    (w_flag_addr)
    );

    ida_link_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_link_mem (
        .i_clk       (i_clk),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (w_rd_addr),
        .o_rd_next   (w_rd_next),
        .o_rd_prev   (w_rd_prev),
        .o_rd_flag   (w_rd_flag),
        .i_wr        (w_wr),
        .i_next_addr (w_next_addr),
        .i_next_data (w_next_data),
        .i_prev_addr (w_prev_addr),
        .i_prev_data (w_prev_data),
        .i_flag_addr (w_flag_addr)
    );

    // Output register: free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result word when the slot frees; otherwise hold it.
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.granted_id   = r_out.granted_id;
    assign o_rsp.oldest_valid = r_out.oldest_valid;
    assign o_rsp.oldest_id    = r_out.oldest_id;
    assign o_rsp.alloc_count  = r_out.alloc_count;

endmodule

/* verif/id_allocator_linked_lists_tb.sv */
// Self-checking testbench of the linked-list id allocator: directed and random traffic against a link-table predictor.
`timescale 1ns / 1ps

// Mirror of the link table: predicts one result word per accepted request word.
class id_book;
    localparam int SIZE = ida_pkg::DEF_TABLE_SIZE;

    logic [7:0]      next_of [SIZE];
    logic [7:0]      prev_of [SIZE];
    bit              held    [SIZE];
    int unsigned     held_count;
    ida_pkg::t_result due[$];
    int unsigned     faults;

    function new();
        for (int i = 0; i < SIZE; i++) begin
            next_of[i] = 8'(i + 1);
            prev_of[i] = 8'(i - 1);
            held[i]    = 1'b0;
        end
        for (int i = 0; i < ida_pkg::FIRST_ID; i++) begin
            next_of[i] = '0;
            prev_of[i] = '0;
        end
        prev_of[ida_pkg::FIRST_ID]          = 8'(ida_pkg::ANCHOR_FREE_HEAD);
        next_of[ida_pkg::ANCHOR_FREE_HEAD]  = 8'(ida_pkg::FIRST_ID);
        next_of[SIZE - 1]                   = 8'(ida_pkg::ANCHOR_FREE_TAIL);
        prev_of[ida_pkg::ANCHOR_FREE_TAIL]  = 8'(SIZE - 1);
        next_of[ida_pkg::ANCHOR_ALLOC_HEAD] = 8'(ida_pkg::ANCHOR_ALLOC_TAIL);
        prev_of[ida_pkg::ANCHOR_ALLOC_TAIL] = 8'(ida_pkg::ANCHOR_ALLOC_HEAD);
        held_count = 0;
        faults     = 0;
    endfunction

    function void unlink(logic [7:0] id);
        logic [7:0] p;
        logic [7:0] n;
        p = prev_of[id];
        n = next_of[id];
        next_of[p] = n;
        prev_of[n] = p;
    endfunction

    function void link_before(logic [7:0] id, logic [7:0] anchor);
        logic [7:0] p;
        p = prev_of[anchor];
        next_of[p]      = id;
        prev_of[id]     = p;
        next_of[id]     = anchor;
        prev_of[anchor] = id;
    endfunction

    // Apply one accepted request word and queue the word it must produce.
    function void take_request(ida_pkg::t_mode mode, logic [7:0] id);
        ida_pkg::t_result r;
        logic [7:0]       cand;
        logic [7:0]       head;
        r.status     = ida_pkg::ST_OK;
        r.granted_id = '0;
        if (mode == ida_pkg::MODE_ALLOC) begin
            cand = next_of[ida_pkg::ANCHOR_FREE_HEAD];
            if (cand < ida_pkg::FIRST_ID) begin
                r.status = ida_pkg::ST_FULL;
            end else begin
                unlink(cand);
                link_before(cand, 8'(ida_pkg::ANCHOR_ALLOC_TAIL));
                held[cand]   = 1'b1;
                held_count++;
                r.granted_id = cand;
            end
        end else begin
            if (id < ida_pkg::FIRST_ID || int'(id) >= SIZE) begin
                r.status = ida_pkg::ST_INVALID;
            end else if (!held[id]) begin
                r.status = ida_pkg::ST_DOUBLE;
            end else begin
                unlink(id);
                link_before(id, 8'(ida_pkg::ANCHOR_FREE_TAIL));
                held[id] = 1'b0;
                held_count--;
            end
        end
        head = next_of[ida_pkg::ANCHOR_ALLOC_HEAD];
        r.oldest_valid = (head >= ida_pkg::FIRST_ID);
        r.oldest_id    = r.oldest_valid ? head : 8'd0;
        r.alloc_count  = 8'(held_count);
        due.push_back(r);
    endfunction

    // Compare one result word with the oldest prediction.
    function void match_result(ida_pkg::t_result got);
        ida_pkg::t_result want;
        if (due.size() == 0) begin
            if (faults < 10)
                $display("unexpected result word: status %0d granted %0d", got.status,
                         got.granted_id);
            faults++;
            return;
        end
        want = due.pop_front();
        if (got.status !== want.status || got.granted_id !== want.granted_id ||
            got.oldest_valid !== want.oldest_valid || got.oldest_id !== want.oldest_id ||
            got.alloc_count !== want.alloc_count) begin
            if (faults < 10) begin
                $write("mismatch: exp status %0d granted %0d oldest %0d/%0d count %0d, ",
                       want.status, want.granted_id, want.oldest_valid, want.oldest_id,
                       want.alloc_count);
                $display("got status %0d granted %0d oldest %0d/%0d count %0d",
                         got.status, got.granted_id, got.oldest_valid,
                         got.oldest_id, got.alloc_count);
            end
            faults++;
        end
    endfunction

    // Random id that is currently allocated; any id when none is.
    function logic [7:0] pick_held();
        int start;
        int k;
        start = $urandom_range(ida_pkg::FIRST_ID, SIZE - 1);
        if (held_count == 0)
            return 8'($urandom_range(0, 255));
        for (int i = 0; i < SIZE; i++) begin
            k = ida_pkg::FIRST_ID + (start - ida_pkg::FIRST_ID + i) % (SIZE - ida_pkg::FIRST_ID);
            if (held[k])
                return 8'(k);
        end
        return 8'(start);
    endfunction
endclass

module id_allocator_linked_lists_tb;
    import ida_pkg::*;

    localparam int TABLE_SIZE = DEF_TABLE_SIZE;

    logic i_clk;
    logic i_rst_n;

    ida_req_if req_bus ();
    ida_rsp_if rsp_bus ();

    id_book book;

    // Stretches without idling on either side; redrawn every few dozen words.
    bit req_quiet;
    bit rsp_quiet;
    int sent_words;
    int seen_words;

    id_allocator_linked_lists #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_rsp  (rsp_bus.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one request word after a random gap and hold it until accepted.
    task automatic send_word(input t_mode mode, input logic [7:0] id);
        int gap;
        if (sent_words % 40 == 0)
            req_quiet = ($urandom_range(0, 3) == 0);
        gap = req_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.mode     <= mode;
        req_bus.entry_id <= id;
        // Sample ready as it stood at the edge; the word moves when both are high.
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        book.take_request(mode, id);
        sent_words++;
    endtask

    // Random words: alloc_pct sets the share of allocate requests; most frees
    // target an id that is allocated, the rest are noise over the whole id range.
    task automatic run_phase(input int words, input int alloc_pct);
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_word(MODE_ALLOC, 8'($urandom));
            else if ($urandom_range(0, 99) < 85)
                send_word(MODE_FREE, book.pick_held());
            else
                send_word(MODE_FREE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: stall at random, check every accepted word.
    initial begin
        t_result got;
        int      gap;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (seen_words % 40 == 0)
                rsp_quiet = ($urandom_range(0, 3) == 0);
            gap = rsp_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
            got.status       = t_status'(rsp_bus.status);
            got.granted_id   = rsp_bus.granted_id;
            got.oldest_valid = rsp_bus.oldest_valid;
            got.oldest_id    = rsp_bus.oldest_id;
            got.alloc_count  = rsp_bus.alloc_count;
            book.match_result(got);
            seen_words++;
        end
    end

    // Main sequence: reset, directed words, random phases, drain, verdict.
    initial begin
        int waited;
        book       = new();
        sent_words = 0;
        seen_words = 0;
        req_quiet  = 1'b0;
        rsp_quiet  = 1'b0;
        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.mode     <= MODE_ALLOC;
        req_bus.entry_id <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first grants, anchors and unallocated ids rejected,
        // oldest and middle frees, refree of a freed id, empty list again.
        send_word(MODE_ALLOC, 8'h00);
        send_word(MODE_ALLOC, 8'hFF);
        send_word(MODE_FREE,  8'h00);
        send_word(MODE_FREE,  8'h01);
        send_word(MODE_FREE,  8'h03);
        send_word(MODE_FREE,  8'hFF);
        send_word(MODE_FREE,  8'h04);
        send_word(MODE_FREE,  8'h04);
        send_word(MODE_ALLOC, 8'hAA);
        send_word(MODE_ALLOC, 8'h55);
        send_word(MODE_ALLOC, 8'h04);
        send_word(MODE_FREE,  8'h07);
        send_word(MODE_FREE,  8'h05);
        send_word(MODE_FREE,  8'h06);
        send_word(MODE_FREE,  8'h08);
        send_word(MODE_FREE,  8'hAA);
        send_word(MODE_FREE,  8'h55);
        send_word(MODE_ALLOC, 8'h00);

        // Fill past full, drain past empty, then mix.
        run_phase(400, 85);
        run_phase(400, 10);
        run_phase(300, 50);

        req_bus.valid <= 1'b0;

        // Wait for every predicted word, with a bound.
        waited = 0;
        while (book.due.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (book.due.size() != 0) begin
            $display("%0d result words never arrived", book.due.size());
            book.faults += book.due.size();
        end
        // Catch any stray word after the last expected one.
        repeat (20) @(posedge i_clk);

        if (book.faults == 0)
            $display("id_allocator_linked_lists_tb: clean");
        else
            $display("id_allocator_linked_lists_tb: errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("id_allocator_linked_lists_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/ida_pkg.sv
hdl/ida_req_if.sv
hdl/ida_rsp_if.sv
hdl/ida_link_mem.sv
hdl/ida_seq.sv
hdl/id_allocator_linked_lists.sv
verif/id_allocator_linked_lists_tb.sv
